/* hw/rtl/tpms_pkg.sv */
// Shared types, constants and helpers of the turntable position move sequencer.
`default_nettype none

package tpms_pkg;

   // Encoder count arithmetic wraps at this width, two's complement
   localparam int COUNT_WIDTH = 32;

   // Field widths
   localparam int ENC_WIDTH   = 32;
   localparam int INDEX_WIDTH = 3;
   localparam int SPEED_WIDTH = 7;
   localparam int CORR_WIDTH  = 10;
   localparam int STEP_WIDTH  = 12;
   localparam int DRIVE_WIDTH = 8;
   localparam int ANGLE_WIDTH = STEP_WIDTH + 2;

   // Port widths
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam int REQ_DATA_WIDTH  = 40;
   localparam int RSP_DATA_WIDTH  = 16;

   // Register reset values and limits
   localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 7'd35;
   localparam logic [CORR_WIDTH-1:0]  CORR_RESET  = 10'd30;
   localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = 12'd270;
   localparam logic [SPEED_WIDTH-1:0] SPEED_MAX   = 7'd100;
   localparam logic [INDEX_WIDTH-1:0] INDEX_LIMIT = 3'd5;

   // Position codes
   localparam logic [INDEX_WIDTH-1:0] POS_ZERO    = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] POS_PLUS_1  = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] POS_MINUS_1 = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] POS_PLUS_2  = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] POS_MINUS_2 = 3'd4;

   typedef logic signed [COUNT_WIDTH-1:0] count_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [DRIVE_WIDTH-1:0] drive_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MOTOR_SPEED = 2'd0,
      CSR_CORRECTION  = 2'd1,
      CSR_STEP_ANGLE  = 2'd2
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_OUT_REV  = 6'b000010,
      PH_OUT_FWD  = 6'b000100,
      PH_BACK_FWD = 6'b001000,
      PH_BACK_REV = 6'b010000,
      PH_SETTLE   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [SPEED_WIDTH-1:0] motor_speed;
      logic [CORR_WIDTH-1:0]  correction_angle;
      logic [STEP_WIDTH-1:0]  step_angle;
   } cfg_type;

   typedef struct packed {
      logic                   op;
      logic [INDEX_WIDTH-1:0] target_index;
      logic [ENC_WIDTH-1:0]   encoder_count;
   } item_type;

   typedef struct packed {
      drive_type              drive;
      logic                   brake;
      logic                   busy_res;
      logic                   move_done;
      logic [INDEX_WIDTH-1:0] current_position;
   } result_type;

   // Signed target angle in counts for a position index
   function automatic angle_type angle_of(input logic [INDEX_WIDTH-1:0] idx,
                                          input logic [STEP_WIDTH-1:0]  step);
      angle_type one_step;
      angle_type res;
      one_step = angle_type'({2'b00, step});
      case (idx)
         POS_PLUS_1:  res = one_step;
         POS_MINUS_1: res = -one_step;
         POS_PLUS_2:  res = one_step <<< 1;
         POS_MINUS_2: res = -(one_step <<< 1);
         default:     res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/tpms_csr.sv */
// Configuration registers of the turntable position move sequencer.
`default_nettype none

module tpms_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tpms_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tpms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output tpms_pkg::cfg_type                         cfg
);

   tpms_pkg::cfg_type cfg_ff;
   tpms_pkg::cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (tpms_pkg::csr_index_type'(csr_index))
            tpms_pkg::CSR_MOTOR_SPEED: begin
               cfg_in.motor_speed = csr_wdata[tpms_pkg::SPEED_WIDTH-1:0];
            end
            tpms_pkg::CSR_CORRECTION: begin
               cfg_in.correction_angle = csr_wdata[tpms_pkg::CORR_WIDTH-1:0];
            end
            tpms_pkg::CSR_STEP_ANGLE: begin
               cfg_in.step_angle = csr_wdata[tpms_pkg::STEP_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold register values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_speed      <= tpms_pkg::SPEED_RESET;
         cfg_ff.correction_angle <= tpms_pkg::CORR_RESET;
         cfg_ff.step_angle       <= tpms_pkg::STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/tpms_seq.sv */
// Move sequencer state and per-beat step logic.
`default_nettype none

module tpms_seq (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           process,
   input  wire tpms_pkg::item_type item,
   input  wire tpms_pkg::cfg_type  cfg,
   output tpms_pkg::result_type res
);

   tpms_pkg::phase_type                   phase_ff, phase_in, phase_mid;
   tpms_pkg::count_type                   start_ff, start_in;
   tpms_pkg::count_type                   rev_ff, rev_in;
   logic [tpms_pkg::INDEX_WIDTH-1:0]      pend_ff, pend_in;
   logic [tpms_pkg::INDEX_WIDTH-1:0]      pos_ff, pos_in;

   tpms_pkg::count_type                   cnt, d, e, from_rev;
   tpms_pkg::count_type                   tgt_c, tgt_lo_c, tgt_hi_c, corr_c;
   tpms_pkg::angle_type                   new_angle, tgt;
   logic signed [tpms_pkg::ANGLE_WIDTH:0] tgt_lo, tgt_hi, corr_s;
   logic [tpms_pkg::SPEED_WIDTH-1:0]      spd;
   tpms_pkg::drive_type                   drv_fwd, drv_rev;
   logic                                  start;

   // Operands
   always_comb begin
      cnt       = tpms_pkg::count_type'($signed(item.encoder_count));
      spd       = (cfg.motor_speed > tpms_pkg::SPEED_MAX) ? tpms_pkg::SPEED_MAX
                                                          : cfg.motor_speed;
      drv_fwd   = tpms_pkg::drive_type'({1'b0, spd});
      drv_rev   = -drv_fwd;
      new_angle = tpms_pkg::angle_of(item.target_index, cfg.step_angle);
      tgt       = tpms_pkg::angle_of(pend_ff, cfg.step_angle);
      corr_s    = $signed({{(tpms_pkg::ANGLE_WIDTH + 1 - tpms_pkg::CORR_WIDTH){1'b0}},
                           cfg.correction_angle});
      tgt_lo    = $signed({tgt[tpms_pkg::ANGLE_WIDTH-1], tgt}) - corr_s;
      tgt_hi    = $signed({tgt[tpms_pkg::ANGLE_WIDTH-1], tgt}) + corr_s;
      tgt_c     = tpms_pkg::count_type'(tgt);
      tgt_lo_c  = tpms_pkg::count_type'(tgt_lo);
      tgt_hi_c  = tpms_pkg::count_type'(tgt_hi);
      corr_c    = tpms_pkg::count_type'(corr_s);
      d         = cnt - start_ff;
      e         = cnt - start_ff - tgt_c;
      from_rev  = cnt - rev_ff;
      start     = item.op && (phase_ff == tpms_pkg::PH_IDLE) &&
                  (item.target_index < tpms_pkg::INDEX_LIMIT);
   end

   // Step the move sequence
   always_comb begin
      phase_in  = phase_ff;
      phase_mid = phase_ff;
      start_in  = start_ff;
      rev_in    = rev_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      res.drive     = '0;
      res.brake     = 1'b0;
      res.move_done = 1'b0;
      if (start) begin
         start_in = cnt;
         pend_in  = item.target_index;
         if (new_angle <= 0) begin
            phase_in  = tpms_pkg::PH_OUT_REV;
            res.drive = drv_rev;
         end else begin
            phase_in  = tpms_pkg::PH_OUT_FWD;
            res.drive = drv_fwd;
         end
      end else begin
         unique case (phase_ff)
            tpms_pkg::PH_OUT_REV: begin
               if (!(d < tgt_lo_c)) begin
                  res.drive = drv_rev;
               end else begin
                  rev_in    = cnt;
                  res.brake = 1'b1;
                  phase_mid = tpms_pkg::PH_BACK_FWD;
               end
            end
            tpms_pkg::PH_OUT_FWD: begin
               if (d < tgt_hi_c) begin
                  res.drive = drv_fwd;
               end else begin
                  rev_in    = cnt;
                  res.brake = 1'b1;
                  phase_mid = tpms_pkg::PH_BACK_REV;
               end
            end
            tpms_pkg::PH_BACK_FWD: begin
               if (from_rev < corr_c) res.drive = drv_fwd;
               else phase_mid = tpms_pkg::PH_SETTLE;
            end
            tpms_pkg::PH_BACK_REV: begin
               if (-corr_c < from_rev) res.drive = drv_rev;
               else phase_mid = tpms_pkg::PH_SETTLE;
            end
            tpms_pkg::PH_SETTLE: begin
               phase_mid = tpms_pkg::PH_SETTLE;
            end
            default: begin
               phase_mid = tpms_pkg::PH_IDLE;
            end
         endcase
         // Settle by bang-bang drive toward the exact target
         if (phase_mid == tpms_pkg::PH_SETTLE) begin
            if (e == '0) begin
               pos_in        = pend_ff;
               phase_mid     = tpms_pkg::PH_IDLE;
               res.move_done = 1'b1;
            end else if (e[tpms_pkg::COUNT_WIDTH-1]) begin
               res.drive = drv_fwd;
            end else begin
               res.drive = drv_rev;
            end
         end
         if (phase_mid == tpms_pkg::PH_IDLE) begin
            res.drive = '0;
            res.brake = 1'b1;
         end
         phase_in = phase_mid;
      end
      res.busy_res         = (phase_in != tpms_pkg::PH_IDLE);
      res.current_position = pos_in;
   end

   // Advance state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tpms_pkg::PH_IDLE;
         start_ff <= '0;
         rev_ff   <= '0;
         pend_ff  <= '0;
         pos_ff   <= '0;
      end else if (process) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         rev_ff   <= rev_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register lost one-hot coding");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      process && res.move_done |=> phase_ff == tpms_pkg::PH_IDLE)
      else $error("move done without returning to idle");

   a_brake_stops: assert property (@(posedge clock) disable iff (reset)
      process && res.brake |-> res.drive == '0)
      else $error("brake applied while driving");

   a_pos_only_on_done: assert property (@(posedge clock) disable iff (reset)
      process && !res.move_done |=> pos_ff == $past(pos_ff))
      else $error("position changed without a completed move");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      process && start |-> res.busy_res && !res.brake)
      else $error("accepted start did not begin a move");

endmodule

`default_nettype wire

/* hw/rtl/turntable_position_move_sequencer_core.sv */
// Top level of the turntable position move sequencer: stream ports and pipeline registers.
// Request to response: input register, one pass of step compares, result register.
// Throughput: one beat per cycle when rsp_tready does not stall the result register.
// The result register frees whenever its beat is taken, so the input side keeps flowing.
// Reset (synchronous, active high): both stages empty, move idle at position 0,
// registers back to motor speed 35, correction 30, step angle 270.
`default_nettype none

module turntable_position_move_sequencer_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // target_index[2:0], encoder_count[34:3], zero fill above
   input  wire logic [tpms_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // op[0]
   input  wire logic [0:0]                           req_tuser,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // drive[7:0], brake[8], busy_res[9], move_done[10], current_position[13:11],
   // zero fill above
   output      logic [tpms_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [tpms_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tpms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int IDX_LO = 0;
   localparam int ENC_LO = tpms_pkg::INDEX_WIDTH;
   localparam int RES_BITS = $bits(tpms_pkg::result_type);

   tpms_pkg::cfg_type    cfg;
   tpms_pkg::item_type   item_ff, item_in;
   tpms_pkg::result_type res, res_ff;
   logic                 in_valid_ff, out_valid_ff;
   logic                 out_free, process;

   tpms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpms_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .process (process),
      .item    (item_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // Handshake between the two stages
   assign out_free   = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || process;

   // Unpack the request beat
   always_comb begin
      item_in.op            = req_tuser[0];
      item_in.target_index  = req_tdata[IDX_LO +: tpms_pkg::INDEX_WIDTH];
      item_in.encoder_count = req_tdata[ENC_LO +: tpms_pkg::ENC_WIDTH];
   end

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (out_free) out_valid_ff <= process;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) item_ff <= item_in;
      if (process) res_ff <= res;
   end

   // Pack the response beat
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[7:0]   = res_ff.drive;
      rsp_tdata[8]     = res_ff.brake;
      rsp_tdata[9]     = res_ff.busy_res;
      rsp_tdata[10]    = res_ff.move_done;
      rsp_tdata[13:11] = res_ff.current_position;
   end

   assign rsp_tvalid = out_valid_ff;

   a_res_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> RES_BITS <= tpms_pkg::RSP_DATA_WIDTH)
      else $error("result does not fit response beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(res_ff))
      else $error("pending result lost before it was taken");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff)
      else $error("stalled request dropped");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the turntable position move sequencer: table-driven and random checks.
`timescale 1ns / 1ps

module tb;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;
   localparam logic [tpms_pkg::INDEX_WIDTH-1:0] INDEX_TOP = 3'd7;

   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 190;
   localparam int RANDOM_PHASES = 6;

   typedef logic [tpms_pkg::INDEX_WIDTH-1:0] index_type;
   typedef logic [tpms_pkg::SPEED_WIDTH-1:0] speed_type;
   typedef logic [tpms_pkg::CORR_WIDTH-1:0]  corr_type;
   typedef logic [tpms_pkg::STEP_WIDTH-1:0]  step_type;
   typedef logic [tpms_pkg::COUNT_WIDTH-1:0] cnt_type;

   // Drive command of one response beat
   typedef struct packed {
      tpms_pkg::drive_type drive;
      logic                brake;
      logic                busy;
      logic                done;
      index_type           position;
   } motor_cmd_type;

   typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_type;

   // A ROW_CFG row carries a cfg_type image in the low bits of value
   typedef struct packed {
      row_kind_type                       kind;
      logic                               op;
      index_type                          idx;
      logic [tpms_pkg::ENC_WIDTH-1:0]     value;
      logic                               typed;
      motor_cmd_type                      want;
   } stim_row_type;

   localparam motor_cmd_type UNTYPED    = '0;
   localparam motor_cmd_type CMD_IDLE0  = '{8'sd0, 1'b1, 1'b0, 1'b0, tpms_pkg::POS_ZERO};
   localparam motor_cmd_type CMD_REV35  = '{-8'sd35, 1'b0, 1'b1, 1'b0, tpms_pkg::POS_ZERO};
   localparam motor_cmd_type CMD_BRAKE0 = '{8'sd0, 1'b1, 1'b1, 1'b0, tpms_pkg::POS_ZERO};
   localparam motor_cmd_type CMD_FWD35  = '{8'sd35, 1'b0, 1'b1, 1'b0, tpms_pkg::POS_ZERO};
   localparam motor_cmd_type CMD_DONE0  = '{8'sd0, 1'b1, 1'b0, 1'b1, tpms_pkg::POS_ZERO};
   localparam motor_cmd_type CMD_REV100 =
      '{-8'sd100, 1'b0, 1'b1, 1'b0, tpms_pkg::POS_PLUS_2};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // target_index[2:0], encoder_count[34:3], zero fill above
   logic [tpms_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   // op[0]
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // drive[7:0], brake[8], busy_res[9], move_done[10], current_position[13:11]
   logic [tpms_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [tpms_pkg::CSR_INDEX_WIDTH-1:0] csr_index = tpms_pkg::CSR_MOTOR_SPEED;
   logic [tpms_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Predicted registers and move state
   speed_type set_speed = tpms_pkg::SPEED_RESET;
   corr_type  set_corr  = tpms_pkg::CORR_RESET;
   step_type  set_step  = tpms_pkg::STEP_RESET;
   tpms_pkg::phase_type seq_phase = tpms_pkg::PH_IDLE;
   cnt_type   start_cnt = '0;
   cnt_type   turn_cnt = '0;
   index_type pend_idx = tpms_pkg::POS_ZERO;
   index_type pos_idx = tpms_pkg::POS_ZERO;

   motor_cmd_type cmd_expect_q[$];
   int mismatch_count = 0;

   // Flow control between the main sequence and the receiver
   bit steady_flow = 1'b0;
   bit sender_burst = 1'b0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Turntable model: encoder position and its largest move per beat
   cnt_type enc_pos = '0;
   int unsigned jump_max = 1;

   stim_row_type directed_rows[26] = '{
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'h0000_0000, 1'b1, CMD_IDLE0},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'h7fff_ffff, 1'b1, CMD_IDLE0},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_MINUS_2, 32'h8000_0000, 1'b1, CMD_IDLE0},
      '{ROW_BEAT, OP_START, tpms_pkg::INDEX_LIMIT, 32'h0000_0000, 1'b1, CMD_IDLE0},
      '{ROW_BEAT, OP_START, INDEX_TOP,             32'hffff_ffff, 1'b1, CMD_IDLE0},
      // move to zero: reverse past by the correction, brake, come back
      '{ROW_BEAT, OP_START, tpms_pkg::POS_ZERO,    32'd100,       1'b1, CMD_REV35},
      '{ROW_BEAT, OP_START, tpms_pkg::POS_PLUS_1,  32'd100,       1'b1, CMD_REV35},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd69,        1'b1, CMD_BRAKE0},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd80,        1'b1, CMD_FWD35},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd99,        1'b1, CMD_FWD35},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd100,       1'b1, CMD_DONE0},
      // positive move across the signed wrap of the count
      '{ROW_BEAT, OP_START, tpms_pkg::POS_PLUS_2,  32'h7fff_ff00, 1'b1, CMD_FWD35},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'h8000_013a, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'h8000_011c, 1'b0, UNTYPED},
      // all registers at their top: speed saturates at the drive limit
      '{ROW_CFG,  OP_TICK,  tpms_pkg::POS_ZERO,
        {3'd0, 7'd127, 10'd1023, 12'd4095}, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_START, tpms_pkg::POS_MINUS_2, 32'h0000_0000, 1'b1, CMD_REV100},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'hffff_dc03, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'hffff_dc02, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'hffff_e001, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'hffff_e002, 1'b0, UNTYPED},
      // all registers at zero: moves with no drive and no overshoot
      '{ROW_CFG,  OP_TICK,  tpms_pkg::POS_ZERO,    32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_BEAT, OP_START, tpms_pkg::POS_MINUS_1, 32'd5,         1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd5,         1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd4,         1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd4,         1'b0, UNTYPED},
      '{ROW_BEAT, OP_TICK,  tpms_pkg::POS_ZERO,    32'd5,         1'b0, UNTYPED}
   };

   turntable_position_move_sequencer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Target offset in counts for a position index
   function automatic cnt_type target_counts(input index_type idx);
      cnt_type one_step;
      one_step = {20'd0, set_step};
      case (idx)
         tpms_pkg::POS_PLUS_1:  return one_step;
         tpms_pkg::POS_MINUS_1: return -one_step;
         tpms_pkg::POS_PLUS_2:  return one_step << 1;
         tpms_pkg::POS_MINUS_2: return -(one_step << 1);
         default:               return '0;
      endcase
   endfunction

   // Advance the move state by one beat and work out its drive command
   task automatic predict_drive_cmd(input logic op, input index_type idx,
                                    input cnt_type cnt,
                                    output motor_cmd_type cmd);
      cnt_type   tgt;
      cnt_type   corr;
      cnt_type   d;
      cnt_type   e;
      speed_type mag;
      int dir;
      mag  = (set_speed > tpms_pkg::SPEED_MAX) ? tpms_pkg::SPEED_MAX : set_speed;
      corr = {22'd0, set_corr};
      dir  = 0;
      cmd  = '0;
      if (op == OP_START && seq_phase == tpms_pkg::PH_IDLE && idx < tpms_pkg::INDEX_LIMIT)
      begin
         start_cnt = cnt;
         pend_idx  = idx;
         if ($signed(target_counts(idx)) <= 0) begin
            seq_phase = tpms_pkg::PH_OUT_REV;
            dir = -1;
         end else begin
            seq_phase = tpms_pkg::PH_OUT_FWD;
            dir = 1;
         end
      end else begin
         tgt = target_counts(pend_idx);
         d   = cnt - start_cnt;
         case (seq_phase)
            tpms_pkg::PH_OUT_REV: begin
               if (!($signed(d) < $signed(tgt - corr))) dir = -1;
               else begin
                  turn_cnt  = cnt;
                  cmd.brake = 1'b1;
                  seq_phase = tpms_pkg::PH_BACK_FWD;
               end
            end
            tpms_pkg::PH_OUT_FWD: begin
               if ($signed(d) < $signed(tgt + corr)) dir = 1;
               else begin
                  turn_cnt  = cnt;
                  cmd.brake = 1'b1;
                  seq_phase = tpms_pkg::PH_BACK_REV;
               end
            end
            tpms_pkg::PH_BACK_FWD: begin
               if ($signed(cnt - turn_cnt) < $signed(corr)) dir = 1;
               else seq_phase = tpms_pkg::PH_SETTLE;
            end
            tpms_pkg::PH_BACK_REV: begin
               if ($signed(-corr) < $signed(cnt - turn_cnt)) dir = -1;
               else seq_phase = tpms_pkg::PH_SETTLE;
            end
            default: ;
         endcase
         // settle by bang-bang drive until the exact target count
         if (seq_phase == tpms_pkg::PH_SETTLE) begin
            e = d - tgt;
            if (e == '0) begin
               pos_idx   = pend_idx;
               seq_phase = tpms_pkg::PH_IDLE;
               cmd.done  = 1'b1;
            end else if (e[tpms_pkg::COUNT_WIDTH-1]) dir = 1;
            else dir = -1;
         end
         if (seq_phase == tpms_pkg::PH_IDLE) begin
            dir = 0;
            cmd.brake = 1'b1;
         end
      end
      if (dir > 0) cmd.drive = tpms_pkg::drive_type'({1'b0, mag});
      else if (dir < 0) cmd.drive = -tpms_pkg::drive_type'({1'b0, mag});
      cmd.busy     = (seq_phase != tpms_pkg::PH_IDLE);
      cmd.position = pos_idx;
   endtask

   // Turn the table by one beat toward the point where the current leg ends
   task automatic move_encoder(input int unsigned roll);
      cnt_type tgt;
      cnt_type corr;
      cnt_type goal;
      cnt_type remaining;
      cnt_type stride;
      logic up;
      tgt    = target_counts(pend_idx);
      corr   = {22'd0, set_corr};
      stride = $urandom_range(0, jump_max);
      case (seq_phase)
         tpms_pkg::PH_OUT_REV:  begin goal = start_cnt + tgt - corr; up = 1'b0; end
         tpms_pkg::PH_OUT_FWD:  begin goal = start_cnt + tgt + corr; up = 1'b1; end
         tpms_pkg::PH_BACK_FWD: begin goal = turn_cnt + corr;        up = 1'b1; end
         tpms_pkg::PH_BACK_REV: begin goal = turn_cnt - corr;        up = 1'b0; end
         default: begin
            goal = start_cnt + tgt;
            up   = $signed(goal - enc_pos) > 0;
         end
      endcase
      remaining = up ? goal - enc_pos : enc_pos - goal;
      if (remaining <= stride && $urandom_range(0, 3) != 0) stride = remaining;
      // now and then the table kicks back a little against the drive
      if (roll >= 94) enc_pos = up ? enc_pos - stride[1:0] : enc_pos + stride[1:0];
      else enc_pos = up ? enc_pos + stride : enc_pos - stride;
   endtask

   // Offer one request beat, wait for it to be taken, record what it must produce
   task automatic send_beat(input logic op, input index_type idx,
                            input cnt_type cnt, input logic typed,
                            input motor_cmd_type want);
      motor_cmd_type predicted;
      while (!steady_flow && !sender_burst && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= {5'd0, cnt, idx};
      req_tuser[0] <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_drive_cmd(op, idx, cnt, predicted);
      cmd_expect_q.push_back(typed ? want : predicted);
   endtask

   // Hold the sender until every response is back and the pipeline is empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (cmd_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input speed_type speed,
                                 input corr_type corr,
                                 input step_type step);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= tpms_pkg::CSR_MOTOR_SPEED;
      csr_wdata <= {5'd0, speed};
      @(posedge clock);
      set_speed = speed;
      csr_index <= tpms_pkg::CSR_CORRECTION;
      csr_wdata <= {2'd0, corr};
      @(posedge clock);
      set_corr = corr;
      csr_index <= tpms_pkg::CSR_STEP_ANGLE;
      csr_wdata <= step;
      @(posedge clock);
      set_step = step;
      csr_we <= 1'b0;
      jump_max = (step + corr) / 16;
      if (jump_max == 0) jump_max = 1;
   endtask

   task automatic log_mismatch(input string what, input motor_cmd_type want,
                               input motor_cmd_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected drive %0d brake %0b busy %0b done %0b pos %0d, ",
                   "got drive %0d brake %0b busy %0b done %0b pos %0d"},
                  $realtime, what, want.drive, want.brake, want.busy, want.done,
                  want.position, got.drive, got.brake, got.busy, got.done, got.position);
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen  <= hold_reqs;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 23);
      end
   end

   // Compare every response beat with the oldest expectation
   always @(posedge clock) begin
      motor_cmd_type got;
      motor_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tdata[10],
                 rsp_tdata[13:11]};
         if (cmd_expect_q.size() == 0) begin
            log_mismatch("response with nothing pending", UNTYPED, got);
         end else begin
            want = cmd_expect_q.pop_front();
            if (got.drive !== want.drive || got.brake !== want.brake ||
                got.busy !== want.busy || got.done !== want.done ||
                got.position !== want.position)
               log_mismatch("response mismatch", want, got);
         end
      end
   end

   // End the run when nothing moves on either side for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      tpms_pkg::cfg_type cfg;
      int unsigned r;
      logic op;
      index_type idx;
      int unsigned phase_speed[RANDOM_PHASES];
      int unsigned phase_corr[RANDOM_PHASES];
      int unsigned phase_step[RANDOM_PHASES];
      phase_speed = '{35, 100, 127, 0, 64, 0};
      phase_corr  = '{30, 0, 1023, 5, 200, 0};
      phase_step  = '{270, 1, 4095, 17, 50, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            cfg = directed_rows[i].value[$bits(tpms_pkg::cfg_type)-1:0];
            apply_settings(cfg.motor_speed, cfg.correction_angle, cfg.step_angle);
         end else begin
            send_beat(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random moves over several register settings
      phase_speed[5] = $urandom_range(0, 127);
      phase_corr[5]  = $urandom_range(0, 63);
      phase_step[5]  = $urandom_range(0, 300);
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_settings(speed_type'(phase_speed[ph]), corr_type'(phase_corr[ph]),
                        step_type'(phase_step[ph]));
         steady_flow <= (ph == 1);
         if (ph == 2) begin
            hold_reqs <= hold_reqs + 1;
            sender_burst = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 60) sender_burst = 1'b0;
            if (ph == 3 && n == 100) wait_drained();
            r = $urandom_range(0, 99);
            if (seq_phase == tpms_pkg::PH_IDLE) begin
               if (r < 70) begin
                  op  = OP_START;
                  idx = index_type'($urandom_range(0, 4));
                  if ($urandom_range(0, 3) == 0) enc_pos = $urandom;
               end else if (r < 80) begin
                  op  = OP_START;
                  idx = index_type'($urandom_range(5, 7));
               end else begin
                  op  = OP_TICK;
                  idx = index_type'($urandom_range(0, 7));
                  if (r >= 90) enc_pos = $urandom;
               end
            end else begin
               move_encoder(r);
               // a start during a move only counts as a tick
               op  = (r < 6) ? OP_START : OP_TICK;
               idx = index_type'($urandom_range(0, 7));
            end
            send_beat(op, idx, enc_pos, 1'b0, UNTYPED);
         end
      end
      steady_flow <= 1'b0;

      wait_drained();
      if (mismatch_count == 0 && cmd_expect_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
